// File: design/cps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Shared widths, constants and transaction types of the column profile
// character segmenter.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int PIX_W = 8;
    localparam int IDX_W = 10;
    localparam int ACC_W = 18;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam logic [PIX_W-1:0] PIX_WHITE      = 8'd255;
    localparam logic [IDX_W-1:0] EDGE_MIN_RESET = 10'd3;

    // One input pixel with its column markers.
    typedef struct packed {
        logic             last_col;
        logic             col_end;
        logic [PIX_W-1:0] pixel;
    } cps_item_t;

    // One found character segment.
    typedef struct packed {
        logic [IDX_W-1:0] seg_width;
        logic [IDX_W-1:0] seg_start;
    } cps_seg_t;

    // Handshake between the core and the output buffer.
    typedef struct packed {
        logic     push;
        cps_seg_t seg;
    } cps_push_t;

endpackage
`default_nettype wire

// File: design/cps_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cps_in_stage
// Input register that holds one pixel transaction for the segmenter core.
// ----------------------------------------------------------------------------
module cps_in_stage
    import cps_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire cps_item_t s_item,
    output logic           item_valid,
    output cps_item_t      item,
    input  wire logic      item_take
);

    logic      valid_reg;
    logic      valid_next;
    cps_item_t item_reg;

    // The register frees when empty or when the core takes its item.
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// File: design/cps_seg_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cps_seg_core
// Column accumulator, region tracking and segment decision, one pixel per
// cycle while the output buffer has room, plus the minimum edge width register.
// ----------------------------------------------------------------------------
module cps_seg_core
    import cps_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_wdata,
    input  wire logic             item_valid,
    input  wire cps_item_t        item,
    input  wire logic             out_ready,
    output logic                  item_take,
    output cps_push_t             out_push
);

    localparam int IDX_MAX_I   = (1 << IDX_W) - 1;
    localparam int IDX_LIMIT_I = (MAX_WIDTH - 1 > IDX_MAX_I) ? IDX_MAX_I : MAX_WIDTH - 1;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_LIMIT_I[IDX_W-1:0];

    logic [IDX_W-1:0] edge_min_reg;
    logic [ACC_W-1:0] accum_reg, accum_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic             in_region_reg, in_region_next;
    logic [IDX_W-1:0] start_reg, start_next;

    logic [ACC_W:0]   sum_wide;
    logic [ACC_W-1:0] sum;
    logic             sum_zero;
    logic [IDX_W-1:0] width;
    logic             emit;

    assign item_take = item_valid && out_ready;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_min_reg <= EDGE_MIN_RESET;
        end else if (cfg_we) begin
            edge_min_reg <= cfg_wdata;
        end
    end

    // Saturating sum of inverted pixels over the column.
    assign sum_wide = {1'b0, accum_reg} + {{(ACC_W + 1 - PIX_W){1'b0}}, PIX_WHITE - item.pixel};
    assign sum      = sum_wide[ACC_W] ? {ACC_W{1'b1}} : sum_wide[ACC_W-1:0];
    assign sum_zero = (sum == '0);
    assign width    = index_reg - start_reg;

    // A segment closes on an empty column; narrow ones at the image edge drop.
    assign emit = item_take && item.col_end && in_region_reg && sum_zero &&
                  (width != '0) && !(item.last_col && (width < edge_min_reg));

    // Next state of the column and region tracking.
    always_comb begin
        accum_next     = accum_reg;
        index_next     = index_reg;
        in_region_next = in_region_reg;
        start_next     = start_reg;
        if (item_take) begin
            if (!item.col_end) begin
                accum_next = sum;
            end else begin
                accum_next = '0;
                if (!in_region_reg && !sum_zero) begin
                    in_region_next = 1'b1;
                    start_next     = index_reg;
                end else if (in_region_reg && sum_zero) begin
                    in_region_next = 1'b0;
                end
                if (item.last_col) begin
                    index_next     = '0;
                    in_region_next = 1'b0;
                end else if (index_reg < IDX_LIMIT) begin
                    index_next = index_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg     <= '0;
            index_reg     <= '0;
            in_region_reg <= 1'b0;
            start_reg     <= '0;
        end else begin
            accum_reg     <= accum_next;
            index_reg     <= index_next;
            in_region_reg <= in_region_next;
            start_reg     <= start_next;
        end
    end

    assign out_push.push          = emit;
    assign out_push.seg.seg_start = start_reg;
    assign out_push.seg.seg_width = width;

    // The image edge always returns to column zero outside a region.
    a_edge_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && item.col_end && item.last_col |=> (index_reg == '0) && !in_region_reg)
        else $error("column state not cleared at image end");

    // Only a closing column produces a segment.
    a_emit_close: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> !in_region_reg)
        else $error("segment emitted while region stays open");

    // The column index never passes its limit.
    a_index_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        index_reg <= IDX_LIMIT)
        else $error("column index beyond limit");

endmodule
`default_nettype wire

// File: design/cps_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cps_out_skid
// Output register with a skid entry, so the upstream ready is registered.
// ----------------------------------------------------------------------------
module cps_out_skid
    import cps_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cps_push_t in_push,
    output logic           in_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output cps_seg_t       m_seg
);

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    cps_seg_t out_reg;
    cps_seg_t skid_reg;
    logic     out_load;

    assign in_ready = !skid_valid_reg;
    assign out_load = !out_valid_reg || m_ready;

    // Output register refills from the skid entry first.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_load) begin
            out_valid_next  = skid_valid_reg || in_push.push;
            skid_valid_next = 1'b0;
        end else if (in_push.push) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= skid_valid_reg ? skid_reg : in_push.seg;
        end else if (in_push.push) begin
            skid_reg <= in_push.seg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_seg   = out_reg;

    // The skid entry is only used behind a held output.
    a_skid_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output");

    // No push arrives while the skid entry is occupied.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !in_push.push)
        else $error("push into full output buffer");

    // A segment pushed into an empty output register is presented there in the next cycle.
    a_push_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        in_push.push && !out_valid_reg |=> out_valid_reg && (out_reg == $past(in_push.seg)))
        else $error("pushed segment not presented");

endmodule
`default_nettype wire

// File: design/column_profile_char_segmenter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_profile_char_segmenter
// Character segmentation of a gray image by its vertical projection profile.
// ----------------------------------------------------------------------------
// Pixels stream in column-major order, one transaction per clock while the
// output buffer has room; the saturating column add and region update in the
// core are combinational. A transaction is held in the input register, and
// the segment it closes is pushed when the core takes it and reaches the
// output register directly or through the skid entry. s_tlast marks the last
// pixel of a column, s_tuser marks the pixels of the last column of the image.
// A column whose inverted sum is nonzero opens a region, an empty column closes
// it and emits start column and width. A region closed by the last column is
// dropped when narrower than the value written on cfg_wdata (reset 3); a region
// still open at the image end is dropped. No reset sweep is needed; the block
// accepts pixels right after reset.
// ----------------------------------------------------------------------------
module column_profile_char_segmenter
    import cps_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_wdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] pixel
    input  wire logic             s_tlast,   // column_end
    input  wire logic             s_tuser,   // [0] last_column
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [23:0]           m_tdata    // [9:0] seg_start, [19:10] seg_width, zero
);

    cps_item_t s_item;
    cps_item_t item;
    logic      item_valid;
    logic      item_take;
    logic      out_ready;
    cps_push_t out_push;
    cps_seg_t  m_seg;

    assign s_item.pixel    = s_tdata[PIX_W-1:0];
    assign s_item.col_end  = s_tlast;
    assign s_item.last_col = s_tuser;

    cps_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    cps_seg_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seg_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .item_take  (item_take),
        .out_push   (out_push)
    );

    cps_out_skid u_out_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_push  (out_push),
        .in_ready (out_ready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_seg    (m_seg)
    );

    assign m_tdata = {4'b0000, m_seg.seg_width, m_seg.seg_start};

endmodule
`default_nettype wire
